### design/mpsf_pkg.sv
// mpsf_pkg: shared types and constants of the multichannel periodic sample fifo
// used by mpsf_ctrl, mpsf_datapath and the top level; depends on nothing

package mpsf_pkg;

  // item field widths
  localparam int CMD_W      = 2;
  localparam int CHAN_W     = 3;
  localparam int WORD_W     = 32;
  localparam int TIME_W     = 32;
  localparam int PERIOD_W   = 31;
  localparam int FILL_W     = 7;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = 32;

  // stream widths
  localparam int S_TDATA_W = WORD_W + TIME_W;          // sample_word, now_us
  localparam int S_TUSER_W = CMD_W + CHAN_W;           // command, channel
  localparam int M_TDATA_W = 80;                       // 74 bits used, padded to bytes

  // delta arithmetic width: signed time difference minus a 31-bit remainder
  localparam int DELTA_W = TIME_W + 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_OFFER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PULL  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

  // single precision nan test masks
  localparam logic [WORD_W-1:0] EXP_MASK  = 32'h7F80_0000;
  localparam logic [WORD_W-1:0] MANT_MASK = 32'h007F_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DELTA,
    ST_COMMIT
  } state_t;

  // sequencer steps handed to the datapath
  typedef struct packed {
    logic load;
    logic fetch;
    logic delta;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  function automatic logic word_is_nan(input logic [WORD_W-1:0] w);
    return ((w & EXP_MASK) == EXP_MASK) && ((w & MANT_MASK) != '0);
  endfunction

endpackage

### design/mpsf_ctrl.sv
// mpsf_ctrl: sequencer of the sample fifo, one item at a time
// steps load, fetch, delta and commit; uses mpsf_pkg

module mpsf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  mpsf_pkg::dp_status_t   status,
  output mpsf_pkg::ctrl_cmd_t    cmd
);
  import mpsf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_DELTA;
      end
      ST_DELTA: begin
        cmd.delta  = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the result register can take the new result
        if (!status.out_busy) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### design/mpsf_datapath.sv
// mpsf_datapath: period registers, per-channel queue state, sample memory,
// due arithmetic and the result register; uses mpsf_pkg, driven by mpsf_ctrl

module mpsf_datapath #(
  parameter int CHANNELS    = 8,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mpsf_pkg::ctrl_cmd_t                cmd,
  output mpsf_pkg::dp_status_t               status,
  input  logic [mpsf_pkg::S_TDATA_W-1:0]     s_tdata,
  input  logic [mpsf_pkg::S_TUSER_W-1:0]     s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [mpsf_pkg::M_TDATA_W-1:0]     m_tdata,
  input  logic                               cfg_write,
  input  logic [mpsf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mpsf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mpsf_pkg::*;

  localparam int PW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW        = $clog2(QUEUE_DEPTH + 1);
  localparam int CIW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW        = CIW + PW;
  localparam int MEM_DEPTH = 1 << AW;
  localparam int PROD_W    = CW + PERIOD_W;

  localparam logic [CW-1:0]          DEPTH_C   = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0]          LAST_PTR  = PW'(QUEUE_DEPTH - 1);
  localparam logic [CHAN_W:0]        CH_LIMIT  = (CHAN_W + 1)'(CHANNELS);
  localparam logic [CFG_INDEX_W:0]   CFG_LIMIT = (CFG_INDEX_W + 1)'(CHANNELS);

  // configuration and per-channel state
  logic [PERIOD_W-1:0] period      [CHANNELS];
  logic [PW-1:0]       head        [CHANNELS];
  logic [PW-1:0]       tail        [CHANNELS];
  logic [PW-1:0]       newest      [CHANNELS];
  logic [CW-1:0]       count       [CHANNELS];
  logic [TIME_W-1:0]   last_time   [CHANNELS];
  logic [PERIOD_W-1:0] remainder   [CHANNELS];
  logic [CHANNELS-1:0] has_stored;

  logic [WORD_W-1:0]   mem [MEM_DEPTH];

  // item under work
  logic [CMD_W-1:0]    cmd_r;
  logic [CHAN_W-1:0]   chan_r;
  logic [WORD_W-1:0]   word_r;
  logic [TIME_W-1:0]   now_r;

  // pipeline of one item
  logic [TIME_W-1:0]        diff_r;
  logic [TIME_W-1:0]        prod_r;
  logic [WORD_W-1:0]        rd_data;
  logic signed [DELTA_W-1:0] delta_r;

  logic                ch_ok;
  logic [CIW-1:0]      ch_i;
  logic [CW-1:0]       cnt_sel;
  logic [PW-1:0]       rd_ptr;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic [PROD_W-1:0]   prod_full;
  logic [CW-1:0]       cnt_m1;
  logic signed [DELTA_W-1:0] period_s;
  logic                forced;
  logic                due;
  logic [PERIOD_W-1:0] rem_new;
  logic [DELTA_W-1:0]  rem_diff;
  logic                store;
  logic                pop;
  logic [CW-1:0]       cnt_after;
  logic [CW+FILL_W-1:0] cnt_ext;
  logic [PW-1:0]       tail_next;
  logic [PW-1:0]       head_next;

  logic [WORD_W-1:0]   res_word;
  logic                res_valid;
  logic                res_due;
  logic                res_stored;
  logic [FILL_W-1:0]   res_fill;
  logic [TIME_W-1:0]   res_first;

  assign ch_ok   = {1'b0, chan_r} < CH_LIMIT;
  assign ch_i    = CIW'(chan_r);
  assign cnt_sel = count[ch_i];

  assign rd_ptr  = (cmd_r == CMD_PULL) ? head[ch_i] : newest[ch_i];
  assign rd_addr = {ch_i, rd_ptr};
  assign wr_addr = {ch_i, tail[ch_i]};

  assign cnt_m1    = cnt_sel - CW'(1);
  assign prod_full = PROD_W'(cnt_m1) * PROD_W'(period[ch_i]);

  assign tail_next = (tail[ch_i] == LAST_PTR) ? '0 : tail[ch_i] + PW'(1);
  assign head_next = (head[ch_i] == LAST_PTR) ? '0 : head[ch_i] + PW'(1);

  // due test: a delta below -period is forced to period, which is then due
  assign period_s = signed'({{(DELTA_W - PERIOD_W){1'b0}}, period[ch_i]});
  assign forced   = delta_r < -period_s;
  assign due      = forced || (delta_r >= period_s);
  assign rem_diff = DELTA_W'(delta_r - period_s);
  assign rem_new  = forced ? '0 : rem_diff[PERIOD_W-1:0];

  always_comb begin
    res_word   = '0;
    res_valid  = 1'b0;
    res_due    = 1'b0;
    res_stored = 1'b0;
    res_first  = '0;
    store      = 1'b0;
    pop        = 1'b0;
    cnt_after  = cnt_sel;
    unique case (cmd_r)
      CMD_OFFER: begin
        res_due = due;
        store   = due && !word_is_nan(word_r) && (cnt_sel != DEPTH_C);
        if (store) begin
          cnt_after = cnt_sel + CW'(1);
        end
        res_stored = store;
      end
      CMD_PULL: begin
        pop = cnt_sel != '0;
        if (pop) begin
          res_word  = rd_data;
          res_valid = 1'b1;
          cnt_after = cnt_sel - CW'(1);
        end
      end
      CMD_PEEK: begin
        if (has_stored[ch_i]) begin
          res_word  = rd_data;
          res_valid = 1'b1;
        end
      end
      CMD_QUERY: begin
        res_first = (cnt_sel == '0) ? last_time[ch_i] : last_time[ch_i] - prod_r;
      end
      default: begin
        res_first = '0;
      end
    endcase
    if (!ch_ok) begin
      res_word   = '0;
      res_valid  = 1'b0;
      res_due    = 1'b0;
      res_stored = 1'b0;
      res_first  = '0;
      store      = 1'b0;
      pop        = 1'b0;
      cnt_after  = '0;
    end
  end

  assign cnt_ext  = {{FILL_W{1'b0}}, cnt_after};
  assign res_fill = cnt_ext[FILL_W-1:0];

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= s_tuser[CMD_W-1:0];
      chan_r <= s_tuser[CMD_W +: CHAN_W];
      word_r <= s_tdata[WORD_W-1:0];
      now_r  <= s_tdata[WORD_W +: TIME_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      diff_r <= now_r - last_time[ch_i];
      prod_r <= prod_full[TIME_W-1:0];
    end
    if (cmd.delta) begin
      delta_r <= signed'({{(DELTA_W - TIME_W){diff_r[TIME_W-1]}}, diff_r})
               - signed'({{(DELTA_W - PERIOD_W){1'b0}}, remainder[ch_i]});
    end
  end

  // sample memory
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rd_data <= mem[rd_addr];
    end
    if (cmd.commit && store) begin
      mem[wr_addr] <= word_r;
    end
  end

  // period registers and per-channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        period[i]    <= '0;
        head[i]      <= '0;
        tail[i]      <= '0;
        newest[i]    <= '0;
        count[i]     <= '0;
        last_time[i] <= '0;
        remainder[i] <= '0;
      end
      has_stored <= '0;
    end else begin
      if (cfg_write && ({1'b0, cfg_index} < CFG_LIMIT)) begin
        period[CIW'(cfg_index)] <= cfg_data[PERIOD_W-1:0];
      end
      if (cmd.commit && ch_ok) begin
        count[ch_i] <= cnt_after;
        if (cmd_r == CMD_OFFER && due) begin
          remainder[ch_i] <= rem_new;
          last_time[ch_i] <= now_r;
        end
        if (store) begin
          newest[ch_i]     <= tail[ch_i];
          tail[ch_i]       <= tail_next;
          has_stored[ch_i] <= 1'b1;
        end
        if (pop) begin
          head[ch_i] <= head_next;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {{(M_TDATA_W - 74){1'b0}}, res_first, res_fill, res_stored, res_due,
                  res_valid, res_word};
    end
  end

  assign status.out_busy = m_tvalid && !m_tready;

endmodule

### design/multichannel_periodic_sample_fifo.sv
// multichannel_periodic_sample_fifo: top level, sequencer plus datapath
// depends on mpsf_pkg, mpsf_ctrl and mpsf_datapath

// Periodic sampler with one ring queue of raw float words per channel. Each item on the slave
// stream is an offer, pull, peek or query for one channel and gives exactly one result on the
// master stream. The block works on one item at a time in four steps: capture at its transfer,
// a fetch step that reads the sample memory and forms the (count-1)*period product, a step that
// forms the signed phase delta, and a commit step that loads the result register. The block
// takes no new item on the slave stream until the previous item has been committed. The commit
// step waits while the previous result still sits unclaimed in the output register. The sample
// memory holds 2**max(1,ceil(log2(CHANNELS))) * 2**max(1,ceil(log2(QUEUE_DEPTH))) words and
// needs no clearing after reset. Period registers are to be written through the cfg port only
// while the block is idle; the block itself does not enforce this. cfg_ready is always high and
// writes to an index at or beyond CHANNELS are dropped.

module multichannel_periodic_sample_fifo #(
  parameter int CHANNELS    = 8,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // sample_word [31:0], now_us [63:32]
  input  logic [mpsf_pkg::S_TDATA_W-1:0]     s_tdata,
  // command [1:0], channel [4:2]
  input  logic [mpsf_pkg::S_TUSER_W-1:0]     s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // read_word [31:0], read_valid [32], was_due [33], was_stored [34],
  // fill_count [41:35], first_time_us [73:42], zero [79:74]
  output logic [mpsf_pkg::M_TDATA_W-1:0]     m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mpsf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mpsf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mpsf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  mpsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mpsf_datapath #(
    .CHANNELS    (CHANNELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // an accepted item blocks the input for its fetch and delta steps
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready)
    else $error("input taken while an item is in flight");

  // a commit only happens when the result register is free
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(m_tvalid && !m_tready))
    else $error("result overwritten before transfer");

  // a stored sample must have been due
  a_stored_due: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[34]) |-> m_tdata[33])
    else $error("sample stored without being due");

  // a read result never comes from an offer
  a_read_not_due: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[32]) |-> !m_tdata[33] && !m_tdata[34])
    else $error("read result mixed with offer flags");

endmodule
